>>> src/hbfs_pkg.sv
// Package for the hashed bucket FIFO store: sizes, command codes, beat types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package hbfs_pkg;
  localparam int unsigned NumBuckets = 256;
  localparam int unsigned PoolDepth  = 1024;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned BktW  = $clog2(NumBuckets);
  localparam int unsigned SlotW = $clog2(PoolDepth);
  localparam int unsigned LenW  = SlotW + 1;
  localparam int unsigned UsedW = BktW + 1;
  localparam int unsigned CfgW  = 9;
  localparam int unsigned HashW = 32;
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    CmdPut   = 3'd0,
    CmdPoll  = 3'd1,
    CmdPeek  = 3'd2,
    CmdDrop  = 3'd3,
    CmdCount = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [HashW-1:0]      hash;
    logic [ValueWidth-1:0] value;
  } job_t;

  typedef enum logic [2:0] {
    BkInit, BkIdle, BkDiv, BkRead, BkLink, BkExec, BkOut
  } bk_state_e;
endpackage
`default_nettype wire

>>> src/hbfs_front.sv
// Front end: hashes key bytes and emits one job per key end.
// Depends on hbfs_pkg.
`default_nettype none
module hbfs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     command_i,
  input  logic           has_byte_i,
  input  logic [7:0]     key_byte_i,
  input  logic           key_last_i,
  input  logic [31:0]    value_in_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output hbfs_pkg::job_t job_o,
  output logic           job_valid_o,
  input  logic           job_ready_i
);
  import hbfs_pkg::*;
  logic [HashW-1:0] hash_q, hash_d, hash_new;
  logic acc;

  assign in_ready_o = !key_last_i || job_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign hash_new = has_byte_i ? {hash_q[HashW-2:0], 1'b0} + HashW'(key_byte_i) : hash_q;
  assign job_valid_o = in_valid_i && key_last_i;
  assign job_o = '{cmd: command_i, hash: hash_new, value: value_in_i[ValueWidth-1:0]};

  always_comb begin
    hash_d = hash_q;
    if (acc) hash_d = key_last_i ? '0 : hash_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hash_q <= '0;
    else hash_q <= hash_d;
  end
endmodule
`default_nettype wire

>>> src/hbfs_queue.sv
// Short job queue between front and back end.
// Depends on hbfs_pkg.
`default_nettype none
module hbfs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hbfs_pkg::job_t wr_job_i,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  output hbfs_pkg::job_t rd_job_o,
  output logic           rd_valid_o,
  input  logic           rd_ready_i
);
  import hbfs_pkg::*;
  job_t mem_q [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth):0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != ($clog2(QDepth)+1)'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_job_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QDepth){1'b0}}, wr} - {{$clog2(QDepth){1'b0}}, rd};
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ($clog2(QDepth)+1)'(QDepth)) else $error("queue overflow");
  a_empty_no_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !rd) else $error("read from empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule
`default_nettype wire

>>> src/hbfs_back.sv
// Back end: bucket modulo, table and pool memories, command sequencer.
// Depends on hbfs_pkg.
`default_nettype none
module hbfs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [8:0]           cfg_data_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  hbfs_pkg::job_t       job_i,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  output logic                 found_o,
  output logic [31:0]          value_out_o,
  output logic [10:0]          chain_count_o,
  output logic [1:0]           status_o,
  output logic [8:0]           buckets_in_use_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);
  import hbfs_pkg::*;
  bk_state_e st_q, st_d;
  logic [CfgW-1:0] bcnt_q;
  logic [BktW:0] div;
  job_t job_q;
  logic [HashW-1:0] rem_q;
  logic [5:0] step_q;
  logic [BktW-1:0] bkt_q, init_b_q;
  logic [SlotW-1:0] init_s_q;

  logic [SlotW-1:0] head_m [NumBuckets];
  logic [SlotW-1:0] tail_m [NumBuckets];
  logic [LenW-1:0]  len_m  [NumBuckets];
  logic [ValueWidth-1:0] val_m [PoolDepth];
  logic [SlotW-1:0] next_m [PoolDepth];

  logic [SlotW-1:0] head_r, tail_r, nxt_r;
  logic [LenW-1:0] len_r;
  logic [ValueWidth-1:0] val_r;
  logic [SlotW-1:0] free_head_q;
  logic [LenW-1:0] free_cnt_q;
  logic [UsedW-1:0] used_q;

  logic found_q; logic [ValueWidth-1:0] vout_q; logic [LenW-1:0] cc_q;
  logic [1:0] stat_q;
  logic [HashW+BktW:0] trial;
  logic [ValueWidth-1:0] ex_vout;
  logic [LenW-1:0] ex_cc;
  logic [1:0] ex_stat;

  assign cfg_ready_o = 1'b1;
  assign div = (bcnt_q == '0) ? (BktW+1)'(1) :
               (bcnt_q > CfgW'(NumBuckets)) ? (BktW+1)'(NumBuckets) : bcnt_q[BktW:0];
  assign job_ready_o = st_q == BkIdle;
  assign out_valid_o = st_q == BkOut;
  assign found_o = found_q;
  assign value_out_o = vout_q;
  assign chain_count_o = cc_q;
  assign status_o = stat_q;
  assign buckets_in_use_o = used_q;
  // restoring division, one quotient bit a step, divisor shifted by step
  assign trial = {{(BktW+1){1'b0}}, rem_q} - ({{HashW{1'b0}}, div} << (6'd31 - step_q));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkInit: if (init_s_q == SlotW'(PoolDepth-1) && init_b_q == BktW'(NumBuckets-1))
                st_d = BkIdle;
      BkIdle: if (job_valid_i) st_d = BkDiv;
      BkDiv:  if (step_q == 6'd31) st_d = BkRead;
      BkRead: st_d = BkLink;
      BkLink: st_d = BkExec;
      BkExec: st_d = BkOut;
      BkOut:  if (out_ready_i) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_comb begin
    ex_vout = '0;
    ex_cc = len_r;
    ex_stat = StOk;
    unique case (job_q.cmd)
      CmdPut: if (free_cnt_q == '0) ex_stat = StFull;
        else ex_cc = len_r + 1'b1;
      CmdPoll: if (len_r == '0) ex_stat = StEmpty;
        else begin
          ex_vout = val_r; ex_cc = len_r - 1'b1;
        end
      CmdPeek: if (len_r == '0) ex_stat = StEmpty; else ex_vout = val_r;
      CmdDrop: if (len_r == '0) ex_stat = StEmpty; else ex_cc = '0;
      default: if (len_r == '0) ex_stat = StEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkInit; bcnt_q <= CfgW'(256);
      init_s_q <= '0; init_b_q <= '0; step_q <= '0;
      free_head_q <= '0; free_cnt_q <= LenW'(PoolDepth); used_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) bcnt_q <= cfg_data_i;
      if (st_q == BkInit) begin
        if (init_s_q != SlotW'(PoolDepth-1)) init_s_q <= init_s_q + 1'b1;
        if (init_b_q != BktW'(NumBuckets-1)) init_b_q <= init_b_q + 1'b1;
      end
      if (st_q == BkDiv) step_q <= step_q + 1'b1;
      else step_q <= '0;
      if (st_q == BkExec) begin
        unique case (job_q.cmd)
          CmdPut: if (free_cnt_q != '0) begin
            free_head_q <= nxt_r; free_cnt_q <= free_cnt_q - 1'b1;
            if (len_r == '0) used_q <= used_q + 1'b1;
          end
          CmdPoll: if (len_r != '0) begin
            free_head_q <= head_r; free_cnt_q <= free_cnt_q + 1'b1;
            if (len_r == LenW'(1)) used_q <= used_q - 1'b1;
          end
          CmdDrop: if (len_r != '0) begin
            free_head_q <= head_r; free_cnt_q <= free_cnt_q + len_r;
            used_q <= used_q - 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BkIdle && job_valid_i) begin
      job_q <= job_i; rem_q <= job_i.hash;
    end
    if (st_q == BkDiv && !trial[HashW+BktW]) rem_q <= trial[HashW-1:0];
    if (st_q == BkDiv && step_q == 6'd31) bkt_q <= trial[HashW+BktW] ? rem_q[BktW-1:0] :
                                                   trial[BktW-1:0];
    if (st_q == BkInit) begin
      next_m[init_s_q] <= (init_s_q == SlotW'(PoolDepth-1)) ? '0 : init_s_q + 1'b1;
      len_m[init_b_q] <= '0;
    end
    if (st_q == BkRead) begin
      head_r <= head_m[bkt_q]; tail_r <= tail_m[bkt_q]; len_r <= len_m[bkt_q];
    end
    if (st_q == BkLink) begin
      nxt_r <= next_m[job_q.cmd == CmdPut ? free_head_q : head_r];
      val_r <= val_m[head_r];
    end
    if (st_q == BkExec) begin
      found_q <= len_r != '0; vout_q <= ex_vout; stat_q <= ex_stat; cc_q <= ex_cc;
      unique case (job_q.cmd)
        CmdPut: if (free_cnt_q != '0) begin
            val_m[free_head_q] <= job_q.value;
            if (len_r == '0) head_m[bkt_q] <= free_head_q;
            else next_m[tail_r] <= free_head_q;
            tail_m[bkt_q] <= free_head_q;
            len_m[bkt_q] <= len_r + 1'b1;
          end
        CmdPoll: if (len_r != '0) begin
            head_m[bkt_q] <= nxt_r;
            next_m[head_r] <= free_head_q;
            len_m[bkt_q] <= len_r - 1'b1;
          end
        CmdDrop: if (len_r != '0) begin
            next_m[tail_r] <= free_head_q; len_m[bkt_q] <= '0;
          end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(NumBuckets)) else $error("bucket count overflow");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= LenW'(PoolDepth)) else $error("free count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(vout_q))
    else $error("result dropped");
`endif
endmodule
`default_nettype wire

>>> src/hashed_bucket_fifo_store.sv
// Top level of the hashed bucket FIFO store: front, job queue, back end.
// Depends on hbfs_pkg, hbfs_front, hbfs_queue, hbfs_back.
// channel | handshake              | payload
// in      | in_valid_i/in_ready_o  | command, has_byte, key_byte, key_last, value_in
// out     | out_valid_o/out_ready_i| found, value_out, chain_count, status, buckets_in_use
// cfg     | cfg_valid_i/cfg_ready_o| cfg_data_i (bucket_count)
// Non-final key bytes are always accepted. In the back end a key end passes through
// accept, 32 steps of the bit-serial modulo, the read states BkRead and BkLink,
// execute and one output beat, which holds while the output is stalled.
// After reset an init pass links the free list; key ends wait for it.
// The queue holds two jobs so bytes keep flowing while the back end works.
`default_nettype none
module hashed_bucket_fifo_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  command_i,
  input  logic        has_byte_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  input  logic [31:0] value_in_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        found_o,
  output logic [31:0] value_out_o,
  output logic [10:0] chain_count_o,
  output logic [1:0]  status_o,
  output logic [8:0]  buckets_in_use_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);
  import hbfs_pkg::*;
  job_t fj, qj;
  logic fv, fr, qv, qr;

  hbfs_front u_front (.clk_i, .rst_ni, .command_i, .has_byte_i, .key_byte_i,
    .key_last_i, .value_in_i, .in_valid_i, .in_ready_o,
    .job_o(fj), .job_valid_o(fv), .job_ready_i(fr));
  hbfs_queue u_queue (.clk_i, .rst_ni, .wr_job_i(fj), .wr_valid_i(fv), .wr_ready_o(fr),
    .rd_job_o(qj), .rd_valid_o(qv), .rd_ready_i(qr));
  hbfs_back u_back (.clk_i, .rst_ni, .cfg_data_i, .cfg_valid_i, .cfg_ready_o,
    .job_i(qj), .job_valid_i(qv), .job_ready_o(qr), .found_o, .value_out_o,
    .chain_count_o, .status_o, .buckets_in_use_o, .out_valid_o, .out_ready_i);
endmodule
`default_nettype wire
